/* rtl/scm_pkg.sv */
// Shared types and constants for the SPI NOR command sequencer.
// Used by scm_front, scm_jobq, scm_back and the top level.
`default_nettype none

package scm_pkg;

	// request codes on the mode field
	localparam logic [2:0] MODE_READ   = 3'd0;
	localparam logic [2:0] MODE_ERASE  = 3'd1;
	localparam logic [2:0] MODE_PROG   = 3'd2;
	localparam logic [2:0] MODE_STATUS = 3'd3;
	localparam logic [2:0] MODE_DATA   = 3'd4;

	// flash opcodes
	localparam logic [7:0] OP_READ3   = 8'h0B;
	localparam logic [7:0] OP_READ4   = 8'h0C;
	localparam logic [7:0] OP_ERASE3  = 8'hD8;
	localparam logic [7:0] OP_ERASE4  = 8'hDC;
	localparam logic [7:0] OP_PROG3   = 8'h02;
	localparam logic [7:0] OP_PROG4   = 8'h12;
	localparam logic [7:0] OP_WREN    = 8'h06;
	localparam logic [7:0] OP_WRDI    = 8'h04;
	localparam logic [7:0] OP_RDSR    = 8'h05;
	localparam logic [7:0] DUMMY_BYTE = 8'hFF;
	localparam int         BUSY_BIT   = 0;

	// configuration register indexes
	localparam logic CFG_FOUR_BYTE = 1'b0;
	localparam logic CFG_PAGE_SIZE = 1'b1;
	localparam logic [9:0] PAGE_SIZE_RST = 10'd256;

	localparam int JQ_DEPTH = 2;

	typedef enum logic [1:0] {
		TAIL_NONE,
		TAIL_DUMMY,
		TAIL_POLL,
		TAIL_WRDI
	} tail_t;

	// order matters: the back end walks the phases upward
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_WREN,
		PH_CMD,
		PH_ADDR,
		PH_BODY,
		PH_TAIL
	} phase_t;

	typedef struct packed {
		logic        wren;
		logic        cmd_en;
		logic [7:0]  cmd;
		logic        four;
		logic [31:0] addr;
		logic        addr_end;
		logic        body_en;
		logic [7:0]  body;
		logic        body_end;
		tail_t       tail;
		logic [23:0] length;
	} job_t;

endpackage

`default_nettype wire

/* rtl/scm_front.sv */
// Front end: takes requests and replies, tracks the operation state and the
// configuration registers, and turns each accepted item that the operation state admits into a job. Uses scm_pkg.
`default_nettype none

module scm_front import scm_pkg::*; #(
	parameter int PAGE_MAX = 512
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [2:0]  mode,
	input  wire logic [31:0] address,
	input  wire logic [23:0] length,
	input  wire logic [7:0]  byte_in,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [9:0]  cfg_data,
	input  wire logic        job_full,
	output logic             job_push,
	output job_t             job
);

	localparam int RW = $clog2(PAGE_MAX + 1);

	logic          four_q;
	logic [9:0]    page_q;
	logic          wait_q, open_q;
	logic [RW-1:0] rem_q;

	logic          wait_d, open_d;
	logic [RW-1:0] rem_d, rem_dec;
	logic          emit, accept, busy;
	logic [23:0]   page_lim, clip;

	assign full      = job_full;
	assign accept    = push && !job_full;
	assign cfg_ready = 1'b1;
	assign job_push  = accept && emit;

	always_comb begin
		busy     = wait_q || open_q;
		page_lim = (24'(page_q) > 24'(PAGE_MAX)) ? 24'(PAGE_MAX) : 24'(page_q);
		clip     = (length < page_lim) ? length : page_lim;
		rem_dec  = (rem_q != '0) ? rem_q - 1'b1 : '0;

		job          = '0;
		job.addr     = address;
		job.length   = length;
		job.four     = four_q;
		job.body     = byte_in;
		job.tail     = TAIL_NONE;
		emit         = 1'b0;
		wait_d       = wait_q;
		open_d       = open_q;
		rem_d        = rem_q;

		unique case (mode)
			MODE_READ: begin
				if (!busy) begin
					emit       = 1'b1;
					job.cmd_en = 1'b1;
					job.cmd    = four_q ? OP_READ4 : OP_READ3;
					job.tail   = TAIL_DUMMY;
				end
			end
			MODE_ERASE: begin
				if (!busy) begin
					emit         = 1'b1;
					job.wren     = 1'b1;
					job.cmd_en   = 1'b1;
					job.cmd      = four_q ? OP_ERASE4 : OP_ERASE3;
					job.addr_end = 1'b1;
					job.tail     = TAIL_POLL;
					wait_d       = 1'b1;
				end
			end
			MODE_PROG: begin
				if (!busy) begin
					emit       = 1'b1;
					job.wren   = 1'b1;
					job.cmd_en = 1'b1;
					job.cmd    = four_q ? OP_PROG4 : OP_PROG3;
					if (clip == '0) begin
						// nothing to write: close on the address and poll right away
						job.addr_end = 1'b1;
						job.tail     = TAIL_POLL;
						wait_d       = 1'b1;
					end else begin
						open_d = 1'b1;
						rem_d  = clip[RW-1:0];
					end
				end
			end
			MODE_STATUS: begin
				if (wait_q) begin
					emit = 1'b1;
					if (byte_in[BUSY_BIT]) begin
						job.tail = TAIL_POLL;
					end else begin
						job.tail = TAIL_WRDI;
						wait_d   = 1'b0;
					end
				end
			end
			MODE_DATA: begin
				if (open_q) begin
					emit         = 1'b1;
					job.body_en  = 1'b1;
					job.body_end = (rem_dec == '0);
					rem_d        = rem_dec;
					if (rem_dec == '0) begin
						open_d   = 1'b0;
						wait_d   = 1'b1;
						job.tail = TAIL_POLL;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			four_q <= 1'b0;
			page_q <= PAGE_SIZE_RST;
			wait_q <= 1'b0;
			open_q <= 1'b0;
			rem_q  <= '0;
		end else begin
			if (accept) begin
				wait_q <= wait_d;
				open_q <= open_d;
				rem_q  <= rem_d;
			end
			if (cfg_valid) begin
				case (cfg_index)
					CFG_FOUR_BYTE: four_q <= cfg_data[0];
					CFG_PAGE_SIZE: page_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/scm_jobq.sv */
// Short job queue between the front and back ends.
// Depth from scm_pkg (power of two); head entry is shown while rd_valid is high.
`default_nettype none

module scm_jobq import scm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire job_t wr_job,
	output logic      full,
	output logic      rd_valid,
	output job_t      rd_job,
	input  wire logic rd_en
);

	localparam int AW = $clog2(JQ_DEPTH);

	job_t          mem [JQ_DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0]   count_q;

	assign full     = (count_q == (AW+1)'(JQ_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_job   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full || rd_en)
		else $error("job written into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> rd_valid)
		else $error("job taken from an empty queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AW+1)'(JQ_DEPTH))
		else $error("job queue count out of range");

endmodule

`default_nettype wire

/* rtl/scm_back.sv */
// Back end: walks each job through its phases (write enable, command,
// address, data, tail) and emits one bus byte per cycle into an output register,
// unless that register is full and not popped. Uses scm_pkg.
`default_nettype none

module scm_back import scm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        jq_valid,
	input  wire job_t        jq_job,
	output logic             jq_pop,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       spi_byte,
	output logic             end_frame,
	output logic [23:0]      receive_count,
	output logic             op_done,
	output logic             last
);

	// first phase strictly after cur that this job has
	function automatic phase_t next_after(input job_t j, input phase_t cur);
		phase_t p;
		p = PH_IDLE;
		if (cur < PH_TAIL && j.tail != TAIL_NONE) p = PH_TAIL;
		if (cur < PH_BODY && j.body_en)           p = PH_BODY;
		if (cur < PH_ADDR && j.cmd_en)            p = PH_ADDR;
		if (cur < PH_CMD  && j.cmd_en)            p = PH_CMD;
		if (cur < PH_WREN && j.wren)              p = PH_WREN;
		return p;
	endfunction

	phase_t     phase_q, phase_d, seq_nxt;
	job_t       job_q;
	logic [1:0] cnt_q, cnt_d, bidx;
	logic       out_valid_q, active, adv, load, addr_final;

	logic [7:0]  byte_d;
	logic        end_d, done_d;
	logic [23:0] recv_d;

	logic [7:0]  spi_byte_q;
	logic        end_frame_q, op_done_q, last_q;
	logic [23:0] receive_count_q;

	assign active     = (phase_q != PH_IDLE);
	assign adv        = active && (!out_valid_q || pop);
	assign addr_final = (cnt_q == (job_q.four ? 2'd3 : 2'd2));
	assign jq_pop     = load;

	// next state
	always_comb begin
		seq_nxt = (phase_q == PH_ADDR && !addr_final) ? PH_ADDR : next_after(job_q, phase_q);
		load    = jq_valid && (!active || (adv && seq_nxt == PH_IDLE));
		if (load) begin
			phase_d = next_after(jq_job, PH_IDLE);
			cnt_d   = '0;
		end else if (adv) begin
			phase_d = seq_nxt;
			cnt_d   = (phase_q == PH_ADDR) ? (addr_final ? 2'd0 : cnt_q + 2'd1) : cnt_q;
		end else begin
			phase_d = phase_q;
			cnt_d   = cnt_q;
		end
	end

	// beat contents for the current phase
	always_comb begin
		bidx   = job_q.four ? 2'd3 - cnt_q : 2'd2 - cnt_q;
		byte_d = 8'h00;
		end_d  = 1'b0;
		recv_d = '0;
		done_d = 1'b0;
		unique case (phase_q)
			PH_WREN: begin
				byte_d = OP_WREN;
				end_d  = 1'b1;
			end
			PH_CMD:  byte_d = job_q.cmd;
			PH_ADDR: begin
				byte_d = job_q.addr[{bidx, 3'b000} +: 8];
				end_d  = addr_final && job_q.addr_end;
			end
			PH_BODY: begin
				byte_d = job_q.body;
				end_d  = job_q.body_end;
			end
			PH_TAIL: begin
				end_d = 1'b1;
				unique case (job_q.tail)
					TAIL_DUMMY: begin
						byte_d = DUMMY_BYTE;
						recv_d = job_q.length;
						done_d = 1'b1;
					end
					TAIL_POLL: begin
						byte_d = OP_RDSR;
						recv_d = 24'd1;
					end
					TAIL_WRDI: begin
						byte_d = OP_WRDI;
						done_d = 1'b1;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= jq_job;
		end
		if (adv) begin
			spi_byte_q      <= byte_d;
			end_frame_q     <= end_d;
			receive_count_q <= recv_d;
			op_done_q       <= done_d;
			last_q          <= (seq_nxt == PH_IDLE);
		end
	end

	assign empty         = !out_valid_q;
	assign spi_byte      = spi_byte_q;
	assign end_frame     = end_frame_q;
	assign receive_count = receive_count_q;
	assign op_done       = op_done_q;
	assign last          = last_q;

	a_addr_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ADDR |-> cnt_q <= (job_q.four ? 2'd3 : 2'd2))
		else $error("address byte counter past the last byte");

	a_body_present: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> job_q.body_en)
		else $error("data phase entered for a job without data");

	a_tail_present: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_TAIL |-> job_q.tail != TAIL_NONE)
		else $error("tail phase entered for a job without tail");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		jq_pop |-> !active || (adv && seq_nxt == PH_IDLE))
		else $error("job loaded while the current one is unfinished");

endmodule

`default_nettype wire

/* rtl/spi_nor_command_sequencer.sv */
// Top level of the SPI NOR command sequencer: front end, job queue, back end.
// Depends on scm_pkg, scm_front, scm_jobq and scm_back.
//
//   channel   handshake            payload
//   request   push / full          mode, address, length, byte_in
//   result    empty / pop          spi_byte, end_frame, receive_count, op_done, last
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A request is classified in the cycle it is accepted; the back end loads it
// from a two-entry job queue and emits one result beat per cycle while the result
// register does not stall it (up to 7 beats per item; ignored items emit none).
// The result register stalls only the back end; the front keeps accepting
// until the job queue fills. Reset clears all operation state, four_byte_address
// to 0 and page_size to 256. cfg_ready is always high.
`default_nettype none

module spi_nor_command_sequencer import scm_pkg::*; #(
	parameter int PAGE_MAX = 512
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [2:0]  mode,
	input  wire logic [31:0] address,
	input  wire logic [23:0] length,
	input  wire logic [7:0]  byte_in,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       spi_byte,
	output logic             end_frame,
	output logic [23:0]      receive_count,
	output logic             op_done,
	output logic             last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [9:0]  cfg_data
);

	job_t fe_job, jq_job;
	logic fe_push, jq_full, jq_valid, jq_pop;

	scm_front #(
		.PAGE_MAX(PAGE_MAX)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.mode      (mode),
		.address   (address),
		.length    (length),
		.byte_in   (byte_in),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.job_full  (jq_full),
		.job_push  (fe_push),
		.job       (fe_job)
	);

	scm_jobq u_jobq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (fe_push),
		.wr_job   (fe_job),
		.full     (jq_full),
		.rd_valid (jq_valid),
		.rd_job   (jq_job),
		.rd_en    (jq_pop)
	);

	scm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.jq_valid      (jq_valid),
		.jq_job        (jq_job),
		.jq_pop        (jq_pop),
		.empty         (empty),
		.pop           (pop),
		.spi_byte      (spi_byte),
		.end_frame     (end_frame),
		.receive_count (receive_count),
		.op_done       (op_done),
		.last          (last)
	);

endmodule

`default_nettype wire
